// File: hw/rtl/vtpy_pkg.sv
// Shared types, constants and the arctangent step table for the pitch/yaw block.
`timescale 1ns / 1ps

package vtpy_pkg;

   // Geometry of the datapath
   localparam int COORD_WIDTH  = 32;
   localparam int CORDIC_STEPS = 24;
   localparam int SCALE_SHIFT  = 60 - COORD_WIDTH;
   localparam int VAL_W        = 64;
   localparam int ANG_W        = 32;
   localparam int DEG_W        = 9;
   localparam int DEG_ONE      = 65536;

   // 1/K in Q30
   localparam logic [29:0] INV_GAIN_Q30 = 30'd652032875;

   // atan(2^-i) in Q16 degrees
   localparam logic [21:0] ATAN_DEG_Q16 [0:31] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
      22'd234379,  22'd117304,  22'd58666,  22'd29335,
      22'd14668,   22'd7334,    22'd3667,   22'd1833,
      22'd917,     22'd458,     22'd229,    22'd115,
      22'd57,      22'd29,      22'd14,     22'd7,
      22'd4,       22'd2,       22'd1,      22'd0,
      22'd0,       22'd0,       22'd0,      22'd0,
      22'd0,       22'd0,       22'd0,      22'd0
   };

   typedef struct packed {
      logic signed [31:0] x_coord;
      logic signed [31:0] y_coord;
      logic signed [31:0] z_coord;
   } vtpy_req_type;

   typedef struct packed {
      logic [DEG_W-1:0] pitch_deg;
      logic [DEG_W-1:0] yaw_deg;
   } vtpy_rsp_type;

   // One pipeline stage of either CORDIC
   typedef struct packed {
      logic                    valid;
      logic signed [VAL_W-1:0] x;
      logic signed [VAL_W-1:0] y;
      logic signed [ANG_W-1:0] ang;
      logic                    bypass;
      logic                    xy_zero;
      logic                    z_zero;
      logic signed [VAL_W-1:0] z_scaled;
      logic signed [ANG_W-1:0] yaw_ang;
   } vtpy_stage_type;

endpackage

// File: hw/rtl/vector_to_pitch_yaw.sv
// Top level: pipelined CORDIC conversion of a 3D vector to pitch and yaw degrees.
`timescale 1ns / 1ps

// Takes one vector per cycle and returns one transaction per vector, in order.
// The pipeline holds an input register, one
// register stage per yaw CORDIC iteration, two stages for the gain multiply
// (split into two 32-bit partial products), one per pitch CORDIC iteration,
// and an output register that converts angles to whole degrees. A stall on
// the result side freezes the whole pipeline, and req_stall follows it.
module vector_to_pitch_yaw
   import vtpy_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  vtpy_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output vtpy_rsp_type rsp_data
);

   localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90 * DEG_ONE);
   localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 * DEG_ONE);

   // One vectoring iteration
   function automatic vtpy_stage_type cordic_step(vtpy_stage_type s, int i);
      vtpy_stage_type          r;
      logic signed [VAL_W-1:0] xs;
      logic signed [VAL_W-1:0] ys;
      logic signed [ANG_W-1:0] da;
      r  = s;
      xs = s.x >>> i;
      ys = s.y >>> i;
      da = ANG_W'(ATAN_DEG_Q16[i]);
      if (!s.bypass) begin
         if (!s.y[VAL_W-1]) begin
            r.x   = s.x + ys;
            r.y   = s.y - xs;
            r.ang = s.ang + da;
         end else begin
            r.x   = s.x - ys;
            r.y   = s.y + xs;
            r.ang = s.ang - da;
         end
      end
      return r;
   endfunction

   // Q16 degrees to whole degrees, truncated toward zero, wrapped
   function automatic logic [DEG_W-1:0] to_degrees(logic signed [ANG_W-1:0] a);
      logic [ANG_W-1:0] mag;
      logic [ANG_W-1:0] qm;
      mag = a[ANG_W-1] ? ANG_W'(-a) : ANG_W'(a);
      qm  = mag >> 16;
      if (a[ANG_W-1] && qm != '0) begin
         return DEG_W'(10'd360 - qm[9:0]);
      end
      return qm[DEG_W-1:0];
   endfunction

   logic advance;

   vtpy_stage_type          yaw_ff [0:CORDIC_STEPS];
   vtpy_stage_type          yaw_in [0:CORDIC_STEPS];
   vtpy_stage_type          pit_ff [0:CORDIC_STEPS];
   vtpy_stage_type          pit_in [0:CORDIC_STEPS];
   vtpy_stage_type          gain_ff, gain_in;
   logic [61:0]             hi_prod_ff, hi_prod_in;
   logic [61:0]             lo_prod_ff, lo_prod_in;
   logic                    rsp_valid_ff;
   vtpy_rsp_type            rsp_data_ff, rsp_data_in;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Input stage: special cases, half-plane fold, scaling
   always_comb begin
      logic signed [VAL_W-1:0] xe, ye, ze, xa, ya;
      xe = VAL_W'(signed'(req_data.x_coord[COORD_WIDTH-1:0]));
      ye = VAL_W'(signed'(req_data.y_coord[COORD_WIDTH-1:0]));
      ze = VAL_W'(signed'(req_data.z_coord[COORD_WIDTH-1:0]));
      xa = xe[VAL_W-1] ? -xe : xe;
      ya = ye[VAL_W-1] ? -ye : ye;
      yaw_in[0]          = '0;
      yaw_in[0].valid    = req_valid;
      yaw_in[0].z_zero   = (ze == '0);
      yaw_in[0].z_scaled = ze <<< SCALE_SHIFT;
      if (xe == '0 && ye == '0) begin
         yaw_in[0].bypass  = 1'b1;
         yaw_in[0].xy_zero = 1'b1;
      end else if (ye == '0) begin
         yaw_in[0].bypass = 1'b1;
         yaw_in[0].x      = xa <<< SCALE_SHIFT;
         yaw_in[0].ang    = xe[VAL_W-1] ? ANG_180 : '0;
      end else if (xe == '0) begin
         yaw_in[0].bypass = 1'b1;
         yaw_in[0].x      = ya <<< SCALE_SHIFT;
         yaw_in[0].ang    = ye[VAL_W-1] ? -ANG_90 : ANG_90;
      end else if (xe[VAL_W-1]) begin
         yaw_in[0].x   = (-xe) <<< SCALE_SHIFT;
         yaw_in[0].y   = (-ye) <<< SCALE_SHIFT;
         yaw_in[0].ang = ye[VAL_W-1] ? -ANG_180 : ANG_180;
      end else begin
         yaw_in[0].x = xe <<< SCALE_SHIFT;
         yaw_in[0].y = ye <<< SCALE_SHIFT;
      end
   end

   // CORDIC iterations, one register stage each
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_steps
      assign yaw_in[k+1] = cordic_step(yaw_ff[k], k);
      assign pit_in[k+1] = cordic_step(pit_ff[k], k);
   end

   // Gain multiply, first half: two partial products
   always_comb begin
      logic [VAL_W-1:0] u;
      u          = yaw_ff[CORDIC_STEPS].x[VAL_W-1] ? '0 : VAL_W'(yaw_ff[CORDIC_STEPS].x);
      gain_in    = yaw_ff[CORDIC_STEPS];
      hi_prod_in = 62'(u[63:32]) * 62'(INV_GAIN_Q30);
      lo_prod_in = 62'(u[31:0]) * 62'(INV_GAIN_Q30);
   end

   // Gain multiply, second half, and pitch CORDIC setup
   always_comb begin
      logic signed [VAL_W-1:0] len;
      len = gain_ff.bypass ? gain_ff.x
                           : signed'(VAL_W'({hi_prod_ff, 2'b00}) + VAL_W'(lo_prod_ff >> 30));
      pit_in[0]         = gain_ff;
      pit_in[0].yaw_ang = gain_ff.ang;
      pit_in[0].x       = len;
      pit_in[0].y       = gain_ff.z_scaled;
      pit_in[0].bypass  = gain_ff.xy_zero || gain_ff.z_zero;
      if (gain_ff.xy_zero) begin
         pit_in[0].ang = (!gain_ff.z_scaled[VAL_W-1] && !gain_ff.z_zero) ? ANG_90 : -ANG_90;
      end else begin
         pit_in[0].ang = '0;
      end
   end

   // Output conversion
   always_comb begin
      rsp_data_in.pitch_deg = to_degrees(pit_ff[CORDIC_STEPS].ang);
      rsp_data_in.yaw_deg   = to_degrees(pit_ff[CORDIC_STEPS].yaw_ang);
   end

   // Pipeline registers; everything moves together, only valid bits are reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= CORDIC_STEPS; k++) begin
            yaw_ff[k].valid <= 1'b0;
            pit_ff[k].valid <= 1'b0;
         end
         gain_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         for (int k = 0; k <= CORDIC_STEPS; k++) begin
            yaw_ff[k] <= yaw_in[k];
            pit_ff[k] <= pit_in[k];
         end
         gain_ff      <= gain_in;
         hi_prod_ff   <= hi_prod_in;
         lo_prod_ff   <= lo_prod_in;
         rsp_valid_ff <= pit_ff[CORDIC_STEPS].valid;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   // Checks
   a_deg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.yaw_deg < 9'd360 && rsp_data.pitch_deg < 9'd360))
      else $error("angle out of range");

   a_pitch_bypass: assert property (@(posedge clock) disable iff (reset)
      (pit_ff[0].valid && pit_ff[0].xy_zero) |-> pit_ff[0].bypass)
      else $error("zero planar vector entered pitch CORDIC");

   a_fixed_len: assert property (@(posedge clock) disable iff (reset)
      (yaw_ff[CORDIC_STEPS].valid && yaw_ff[CORDIC_STEPS].bypass
       && !yaw_ff[CORDIC_STEPS].xy_zero) |-> (yaw_ff[CORDIC_STEPS].x > 0))
      else $error("axis-aligned planar length not positive");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pit_ff[CORDIC_STEPS].valid))
      else $error("pipeline moved while stalled");

endmodule
